/* hdl/hbbc_pkg.sv */
// Shared types, constants and the bucket hash step of the hashed block buffer cache.
`default_nettype none
package hbbc_pkg;

    localparam int NUM_SLOTS   = 30;
    localparam int NUM_BUCKETS = 13;
    localparam int SLOT_W      = 5;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int BKT_W       = 4;
    localparam int RECIP_SH    = 12;
    localparam int RECIP       = (1 << RECIP_SH) / NUM_BUCKETS;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]        dev;
        logic [31:0]       blk;
        logic              valid;
        logic [7:0]        cnt;
        logic [BKT_W-1:0]  bkt;
        logic [SLOT_W-1:0] rank;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One nibble of the block number folded into the running remainder.
    function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] rem,
                                                  input logic [3:0] nib);
        logic [7:0]  x;
        logic [20:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        x    = {rem, nib};
        prod = 21'(x) * 21'(RECIP);
        q    = 8'(prod >> RECIP_SH);
        r    = x - 8'(q * 8'(NUM_BUCKETS));
        if (r >= 8'(NUM_BUCKETS)) begin
            r = r - 8'(NUM_BUCKETS);
        end
        return r[BKT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/hbbc_tag_ram.sv */
// Tag memory: one entry per buffer slot, one write and one registered read port.
`default_nettype none
module hbbc_tag_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [hbbc_pkg::SLOT_W-1:0]   i_waddr,
    input  wire hbbc_pkg::t_entry              i_wdata,
    input  wire logic                          i_re,
    input  wire logic [hbbc_pkg::SLOT_W-1:0]   i_raddr,
    output hbbc_pkg::t_entry                   o_rdata
);

    hbbc_pkg::t_entry r_mem [hbbc_pkg::NUM_SLOTS];
    hbbc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/hashed_block_buffer_cache.sv */
// Top level: request sequencer of the hashed block buffer cache around the tag memory.
//
//  Channel  Dir  Signals                       Contents
//  s_*      in   s_tvalid s_tready s_tdata     device, block_number, buffer_index
//                s_tuser                       opcode
//  m_*      out  m_tvalid m_tready m_tdata     slot, hit, needs_read, status
//
// A read hashes the block number a nibble at a time, makes a pass over the tag memory, takes a
// decision and makes one write, or a rank pass when a slot moves in from another bucket.
// Release, pin and unpin look up the slot and write it back, or make a rank pass when a
// release ranks a slot newest; an index beyond the pool answers without a lookup.
// After reset a clearing pass fills every tag memory entry before s_tready rises.
// The result register lets the next request start while a result waits on m_tready.
`default_nettype none
module hashed_block_buffer_cache (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // device[7:0], block_number[39:8], buffer_index[44:40]
    input  wire logic [1:0]  s_tuser,  // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // slot[4:0], hit[5], needs_read[6], status[8:7]
);

    localparam int SW = hbbc_pkg::SLOT_W;
    localparam int CW = hbbc_pkg::CNT_W;
    localparam int BW = hbbc_pkg::BKT_W;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_HASH   = 10'b0000000100,
        S_SCAN   = 10'b0000001000,
        S_DECIDE = 10'b0000010000,
        S_LOOK   = 10'b0000100000,
        S_LOOKD  = 10'b0001000000,
        S_WRITE  = 10'b0010000000,
        S_SWEEP  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_pv;
    logic [SW-1:0]     r_paddr;
    hbbc_pkg::t_op     r_op;
    logic [7:0]        r_dev;
    logic [31:0]       r_blk;
    logic [31:0]       r_hsh;
    logic [2:0]        r_hcnt;
    logic [SW-1:0]     r_idx;
    logic [BW-1:0]     r_bkt;
    logic              r_hit_f, r_own_f, r_oth_f;
    logic [SW-1:0]     r_hit_a, r_own_a, r_oth_a;
    hbbc_pkg::t_entry  r_hit_e, r_own_e, r_oth_e;
    logic [SW-1:0]     r_tgt_a;
    hbbc_pkg::t_entry  r_tgt_e;
    hbbc_pkg::t_entry  n_tgt_e;
    logic [SW-1:0]     r_old;
    logic [SW-1:0]     r_slot;
    logic              r_hit, r_nread;
    hbbc_pkg::t_status r_status;
    logic              r_ovalid;
    logic [15:0]       r_odata;

    logic              ram_we, ram_re;
    logic [SW-1:0]     ram_waddr, ram_raddr;
    hbbc_pkg::t_entry  ram_wdata, ram_rdata, aged;
    logic              cnt_end, out_free;

    hbbc_tag_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cnt_end  = (r_cnt == CW'(hbbc_pkg::NUM_SLOTS));
    assign out_free = !r_ovalid || m_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;

    always_comb begin
        aged = ram_rdata;
        if (ram_rdata.rank > r_old) begin
            aged.rank = ram_rdata.rank - SW'(1);
        end
    end

    always_comb begin
        n_tgt_e = r_tgt_e;
        if (r_state == S_DECIDE) begin
            if (r_hit_f) begin
                n_tgt_e       = r_hit_e;
                n_tgt_e.valid = 1'b1;
                n_tgt_e.cnt   = (r_hit_e.cnt == 8'hFF) ? 8'hFF : r_hit_e.cnt + 8'd1;
            end else if (r_own_f) begin
                n_tgt_e       = r_own_e;
                n_tgt_e.dev   = r_dev;
                n_tgt_e.blk   = r_blk;
                n_tgt_e.valid = 1'b1;
                n_tgt_e.cnt   = 8'd1;
            end else begin
                n_tgt_e       = r_oth_e;
                n_tgt_e.dev   = r_dev;
                n_tgt_e.blk   = r_blk;
                n_tgt_e.valid = 1'b1;
                n_tgt_e.cnt   = 8'd1;
                n_tgt_e.bkt   = r_bkt;
                n_tgt_e.rank  = SW'(hbbc_pkg::NUM_SLOTS - 1);
            end
        end else if (r_state == S_LOOKD) begin
            n_tgt_e = ram_rdata;
            if (r_op == hbbc_pkg::OP_PIN) begin
                n_tgt_e.cnt = (ram_rdata.cnt == 8'hFF) ? 8'hFF : ram_rdata.cnt + 8'd1;
            end else if (ram_rdata.cnt != 8'd0) begin
                n_tgt_e.cnt = ram_rdata.cnt - 8'd1;
                if (r_op == hbbc_pkg::OP_RELEASE && ram_rdata.cnt == 8'd1) begin
                    n_tgt_e.rank = SW'(hbbc_pkg::NUM_SLOTS - 1);
                end
            end
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_cnt[SW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_cnt[SW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we         = 1'b1;
                ram_wdata.rank = r_cnt[SW-1:0];
            end
            S_SCAN: begin
                ram_re = !cnt_end;
            end
            S_LOOK: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_tgt_a;
                ram_wdata = r_tgt_e;
            end
            S_SWEEP: begin
                ram_re    = !cnt_end;
                ram_we    = r_pv;
                ram_waddr = r_paddr;
                ram_wdata = (r_paddr == r_tgt_a) ? r_tgt_e : aged;
            end
            S_IDLE, S_HASH, S_DECIDE, S_LOOKD, S_DONE: begin
                ram_re = 1'b0;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= (r_ovalid && !m_tready) || (r_state == S_DONE && out_free);
            r_tgt_e  <= n_tgt_e;
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(hbbc_pkg::NUM_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_op     <= hbbc_pkg::t_op'(s_tuser);
                        r_dev    <= s_tdata[7:0];
                        r_blk    <= s_tdata[39:8];
                        r_hsh    <= s_tdata[39:8];
                        r_idx    <= s_tdata[44:40];
                        r_bkt    <= '0;
                        r_hcnt   <= '0;
                        r_slot   <= s_tdata[44:40];
                        r_hit    <= 1'b0;
                        r_nread  <= 1'b0;
                        r_status <= hbbc_pkg::ST_OK;
                        if (hbbc_pkg::t_op'(s_tuser) == hbbc_pkg::OP_READ) begin
                            r_state <= S_HASH;
                        end else if (s_tdata[44:40] >= SW'(hbbc_pkg::NUM_SLOTS)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_HASH: begin
                    r_bkt  <= hbbc_pkg::mod_step(r_bkt, r_hsh[31:28]);
                    r_hsh  <= r_hsh << 4;
                    r_hcnt <= r_hcnt + 3'd1;
                    if (r_hcnt == 3'd7) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_hit_f <= 1'b0;
                        r_own_f <= 1'b0;
                        r_oth_f <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_pv    <= ram_re;
                    r_paddr <= r_cnt[SW-1:0];
                    if (ram_re) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_pv) begin
                        if (ram_rdata.bkt == r_bkt && ram_rdata.dev == r_dev &&
                            ram_rdata.blk == r_blk &&
                            (!r_hit_f || ram_rdata.rank > r_hit_e.rank)) begin
                            r_hit_f <= 1'b1;
                            r_hit_a <= r_paddr;
                            r_hit_e <= ram_rdata;
                        end
                        if (ram_rdata.bkt == r_bkt && ram_rdata.cnt == 8'd0 &&
                            (!r_own_f || ram_rdata.rank < r_own_e.rank)) begin
                            r_own_f <= 1'b1;
                            r_own_a <= r_paddr;
                            r_own_e <= ram_rdata;
                        end
                        if (ram_rdata.bkt != r_bkt && ram_rdata.cnt == 8'd0 &&
                            (!r_oth_f || ram_rdata.bkt < r_oth_e.bkt ||
                             (ram_rdata.bkt == r_oth_e.bkt &&
                              ram_rdata.rank < r_oth_e.rank))) begin
                            r_oth_f <= 1'b1;
                            r_oth_a <= r_paddr;
                            r_oth_e <= ram_rdata;
                        end
                    end
                    if (!ram_re && !r_pv) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cnt <= '0;
                    r_pv  <= 1'b0;
                    if (r_hit_f) begin
                        r_tgt_a <= r_hit_a;
                        r_slot  <= r_hit_a;
                        r_hit   <= 1'b1;
                        r_nread <= !r_hit_e.valid;
                        r_state <= S_WRITE;
                    end else if (r_own_f) begin
                        r_tgt_a <= r_own_a;
                        r_slot  <= r_own_a;
                        r_nread <= 1'b1;
                        r_state <= S_WRITE;
                    end else if (r_oth_f) begin
                        r_tgt_a <= r_oth_a;
                        r_old   <= r_oth_e.rank;
                        r_slot  <= r_oth_a;
                        r_nread <= 1'b1;
                        r_state <= S_SWEEP;
                    end else begin
                        r_slot   <= '0;
                        r_status <= hbbc_pkg::ST_NO_FREE;
                        r_state  <= S_DONE;
                    end
                end
                S_LOOK: begin
                    r_state <= S_LOOKD;
                end
                S_LOOKD: begin
                    r_cnt   <= '0;
                    r_pv    <= 1'b0;
                    r_tgt_a <= r_idx;
                    r_old   <= ram_rdata.rank;
                    if (r_op == hbbc_pkg::OP_PIN) begin
                        r_state <= S_WRITE;
                    end else if (ram_rdata.cnt == 8'd0) begin
                        r_status <= hbbc_pkg::ST_UNDERFLOW;
                        r_state  <= S_DONE;
                    end else if (r_op == hbbc_pkg::OP_RELEASE && ram_rdata.cnt == 8'd1) begin
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_SWEEP: begin
                    r_pv    <= ram_re;
                    r_paddr <= r_cnt[SW-1:0];
                    if (ram_re) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (!ram_re && !r_pv) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_odata <= {7'd0, r_status, r_nread, r_hit, r_slot};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr < SW'(hbbc_pkg::NUM_SLOTS)))
        else $error("tag write beyond the slot pool");

    a_scan_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_HASH) |-> !ram_we)
        else $error("tag write during the lookup pass");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the completion step");

    a_no_free_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == hbbc_pkg::ST_NO_FREE) |-> (r_slot == '0 && !r_hit))
        else $error("no-free result carries a slot");

endmodule
`default_nettype wire
